FILE: hw/rtl/dsl_pkg.sv
// ----------------------------------------------------------------------------
// dsl_pkg
// Shared types, constants and helpers for the differential drive slew limiter.
// ----------------------------------------------------------------------------
package dsl_pkg;

  // Field widths.
  localparam int LEVEL_W   = 16;
  localparam int LIMIT_W   = 15;
  localparam int STEP_W    = 15;
  localparam int MODE_W    = 2;
  localparam int ACTION_W  = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 15;

  // Divider geometry: a 32-bit dividend, a 16-bit divisor and quotient,
  // two quotient bits per cycle.
  localparam int DIVIDEND_W = 32;
  localparam int DIVISOR_W  = 16;
  localparam int QUOT_W     = 16;
  localparam int DIV_BITS_PER_CYCLE = 2;
  localparam int DIV_ITERS  = QUOT_W / DIV_BITS_PER_CYCLE;
  localparam int DIV_CNT_W  = $clog2(DIV_ITERS);

  // Product of a magnitude and the limit.
  localparam int PROD_W = LEVEL_W + LIMIT_W;

  // Step used when a magnitude falls, and the reset value of the rise step.
  localparam logic [STEP_W-1:0] FALL_STEP       = STEP_W'(25600);
  localparam logic [STEP_W-1:0] RISE_STEP_RESET = STEP_W'(25600);

  // Command kinds.
  typedef enum logic [MODE_W-1:0] {
    MODE_STOP    = 2'd0,
    MODE_VOLTS   = 2'd1,
    MODE_CHAINED = 2'd2,
    MODE_SWING   = 2'd3
  } mode_t;

  // Per-side actions.
  typedef enum logic [ACTION_W-1:0] {
    ACT_DRIVE = 2'd0,
    ACT_BRAKE = 2'd1,
    ACT_HOLD  = 2'd2,
    ACT_KEEP  = 2'd3
  } action_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RISE_STEP  = 1'b0,
    CFG_BRAKE_MODE = 1'b1
  } cfg_reg_t;

  // Request from the sequencer to the divider.
  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  // Status from the divider back to the sequencer.
  typedef struct packed {
    logic              busy;
    logic              done;
    logic [QUOT_W-1:0] quotient;
  } div_status_t;

  // Magnitude of a signed level; the most negative level maps to 32768.
  function automatic logic [LEVEL_W-1:0] mag(input logic signed [LEVEL_W-1:0] x);
    logic [LEVEL_W-1:0] r;
    r = x[LEVEL_W-1] ? LEVEL_W'(-x) : LEVEL_W'(x);
    return r;
  endfunction

endpackage

FILE: hw/rtl/dsl_if.sv
// ----------------------------------------------------------------------------
// dsl_if
// Valid/ready channels for drive commands and for limited drive results.
// ----------------------------------------------------------------------------

// Drive command channel.
interface dsl_cmd_if;
  import dsl_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [MODE_W-1:0]          mode;
  logic signed [LEVEL_W-1:0]  left_target;
  logic signed [LEVEL_W-1:0]  right_target;
  logic [LIMIT_W-1:0]         max_level;

  modport source (output valid, output mode, output left_target,
                  output right_target, output max_level, input ready);
  modport sink   (input valid, input mode, input left_target,
                  input right_target, input max_level, output ready);
endinterface

// Drive result channel.
interface dsl_res_if;
  import dsl_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [LEVEL_W-1:0]  left_level;
  logic signed [LEVEL_W-1:0]  right_level;
  logic [ACTION_W-1:0]        left_action;
  logic [ACTION_W-1:0]        right_action;
  logic                       done_res;

  modport source (output valid, output left_level, output right_level,
                  output left_action, output right_action, output done_res,
                  input ready);
  modport sink   (input valid, input left_level, input right_level,
                  input left_action, input right_action, input done_res,
                  output ready);
endinterface

FILE: hw/rtl/dsl_divider.sv
// ----------------------------------------------------------------------------
// dsl_divider
// Iterative unsigned restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module dsl_divider (
  input  logic                 clk,
  input  logic                 rst,
  input  dsl_pkg::div_req_t    req,
  output dsl_pkg::div_status_t status
);
  import dsl_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIVISOR_W-1:0] rem;
  logic [QUOT_W-1:0]    sh;
  logic [DIVISOR_W-1:0] dvs;

  logic [DIVISOR_W:0]   s1;
  logic [DIVISOR_W:0]   s2;
  logic [QUOT_W-1:0]    sh1;
  logic [QUOT_W-1:0]    sh2;

  // One restoring step: returns the quotient bit over the new remainder.
  function automatic logic [DIVISOR_W:0] div_step(input logic [DIVISOR_W-1:0] r,
                                                  input logic b,
                                                  input logic [DIVISOR_W-1:0] d);
    logic [DIVISOR_W:0] t;
    logic [DIVISOR_W:0] res;
    t = {r, b};
    if (t >= {1'b0, d}) begin
      res = {1'b1, DIVISOR_W'(t - {1'b0, d})};
    end else begin
      res = {1'b0, t[DIVISOR_W-1:0]};
    end
    return res;
  endfunction

  // Two dependent steps per cycle; quotient bits shift in at the bottom.
  always_comb begin
    s1  = div_step(rem, sh[QUOT_W-1], dvs);
    sh1 = {sh[QUOT_W-2:0], s1[DIVISOR_W]};
    s2  = div_step(s1[DIVISOR_W-1:0], sh1[QUOT_W-1], dvs);
    sh2 = {sh1[QUOT_W-2:0], s2[DIVISOR_W]};
  end

  // Control: iteration counter, busy and a one-cycle done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !req.start && (cnt == DIV_CNT_W'(DIV_ITERS - 1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_ITERS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Datapath. The upper dividend half is below the divisor, so the
  // remainder starts there and the quotient fits the lower half.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.dividend[DIVIDEND_W-1:QUOT_W];
      sh  <= req.dividend[QUOT_W-1:0];
      dvs <= req.divisor;
    end else if (busy) begin
      rem <= s2[DIVISOR_W-1:0];
      sh  <= sh2;
    end
  end

  assign status.busy     = busy;
  assign status.done     = done;
  assign status.quotient = sh;

  // A new division never starts on top of one in flight.
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy)
    else $error("divider started while busy");

  // The last iteration is always followed by the done pulse.
  a_done_after_last: assert property (@(posedge clk) disable iff (rst)
    (busy && !req.start && cnt == DIV_CNT_W'(DIV_ITERS - 1)) |=> done)
    else $error("divider missed its done pulse");

  // Done is only reported once the unit has gone idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("divider done while still busy");

endmodule

FILE: hw/rtl/dsl_slew.sv
// ----------------------------------------------------------------------------
// dsl_slew
// Slew limiter for one side: moves the current level toward the target by at
// most one step, with the full fall step whenever the magnitude drops.
// ----------------------------------------------------------------------------
module dsl_slew (
  input  logic signed [dsl_pkg::LEVEL_W-1:0] target,
  input  logic signed [dsl_pkg::LEVEL_W-1:0] current,
  input  logic        [dsl_pkg::STEP_W-1:0]  rise_step,
  output logic signed [dsl_pkg::LEVEL_W-1:0] level
);
  import dsl_pkg::*;

  localparam int EXT_W = LEVEL_W + 2;

  logic [STEP_W-1:0]      step;
  logic signed [EXT_W-1:0] cur_x;
  logic signed [EXT_W-1:0] tgt_x;
  logic signed [EXT_W-1:0] step_x;
  logic signed [EXT_W-1:0] up;
  logic signed [EXT_W-1:0] dn;

  // Step choice: fall step when the magnitude drops or the rise step is zero.
  always_comb begin
    if (rise_step == '0 || mag(current) > mag(target)) begin
      step = FALL_STEP;
    end else begin
      step = rise_step;
    end
  end

  // Window around the current level.
  always_comb begin
    cur_x  = EXT_W'(current);
    tgt_x  = EXT_W'(target);
    step_x = signed'({{(EXT_W-STEP_W){1'b0}}, step});
    up     = cur_x + step_x;
    dn     = cur_x - step_x;
  end

  // Clamp the target into the window; the result lies between current and
  // target, so it always fits the level width.
  always_comb begin
    priority if (tgt_x > up) begin
      level = up[LEVEL_W-1:0];
    end else if (tgt_x < dn) begin
      level = dn[LEVEL_W-1:0];
    end else begin
      level = target;
    end
  end

endmodule

FILE: hw/rtl/differential_drive_slew_limiter.sv
// ----------------------------------------------------------------------------
// differential_drive_slew_limiter
// Scales a left/right drive command into the command's limit, slew-limits
// each side against the last applied level and reports per-side actions.
// ----------------------------------------------------------------------------
// A command is taken only while the sequencer is idle and is then worked one
// side at a time. A stop or a swing with both sides nonzero goes from the
// transfer straight to the write state. Each driven side passes the prep and
// slew states; when its targets must be scaled into the limit, the multiply in
// prep is followed by the start and divide states, which wait on the shared
// divider at two quotient bits per cycle. The worst case is two scaled sides.
// The result sits in an output register, so the next command may be taken
// while it waits. Levels are signed, in 1/128 percent. The brake_mode index
// is accepted on the configuration port but not stored here; brake actions
// only mark where it takes effect.
// ----------------------------------------------------------------------------
module differential_drive_slew_limiter (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [dsl_pkg::CFG_IDX_W-1:0]        cfg_addr,
  input  logic [dsl_pkg::CFG_DATA_W-1:0]       cfg_data,
  dsl_cmd_if.sink                              cmd,
  dsl_res_if.source                            res
);
  import dsl_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PREP  = 6'b000010,
    S_START = 6'b000100,
    S_DIV   = 6'b001000,
    S_SLEW  = 6'b010000,
    S_WRITE = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  // Configuration.
  logic [STEP_W-1:0] rise_step;

  // Kept levels.
  logic signed [LEVEL_W-1:0] last_left;
  logic signed [LEVEL_W-1:0] last_right;

  // Command working registers.
  logic                      stop_cmd;
  logic signed [LEVEL_W-1:0] lt_r;
  logic signed [LEVEL_W-1:0] rt_r;
  logic [LIMIT_W-1:0]        lim_r;
  logic [LEVEL_W-1:0]        peak_r;
  logic                      side;
  logic                      also_right;
  logic                      neg_r;
  logic [PROD_W-1:0]         prod;
  logic signed [LEVEL_W-1:0] scaled;
  logic signed [LEVEL_W-1:0] lo_w;
  logic signed [LEVEL_W-1:0] ro_w;
  logic [ACTION_W-1:0]       la_w;
  logic [ACTION_W-1:0]       ra_w;
  logic                      done_w;

  // Output register.
  logic                      res_valid;
  logic signed [LEVEL_W-1:0] res_left;
  logic signed [LEVEL_W-1:0] res_right;
  logic [ACTION_W-1:0]       res_la;
  logic [ACTION_W-1:0]       res_ra;
  logic                      res_done;

  // Combinational helpers.
  logic                      cmd_xfer;
  logic                      res_xfer;
  logic                      res_free;
  logic [LEVEL_W-1:0]        lt_mag;
  logic [LEVEL_W-1:0]        rt_mag;
  logic                      need_scale;
  logic signed [LEVEL_W-1:0] side_target;
  logic signed [LEVEL_W-1:0] cur_lvl;
  logic signed [LEVEL_W-1:0] slew_out;
  logic signed [LEVEL_W-1:0] quot_s;

  div_req_t    div_req;
  div_status_t div_st;

  assign cmd_xfer   = cmd.valid && cmd.ready;
  assign res_xfer   = res_valid && res.ready;
  assign res_free   = !res_valid || res.ready;
  assign lt_mag     = mag(cmd.left_target);
  assign rt_mag     = mag(cmd.right_target);
  assign need_scale = peak_r > {1'b0, lim_r};
  assign side_target = side ? rt_r : lt_r;
  assign cur_lvl    = side ? last_right : last_left;
  assign quot_s     = signed'(div_st.quotient);

  assign cmd.ready = (state == S_IDLE) && !rst;

  // Shared divider and slew unit.
  assign div_req.start    = (state == S_START);
  assign div_req.dividend = DIVIDEND_W'(prod);
  assign div_req.divisor  = peak_r;

  dsl_divider u_div (
    .clk    (clk),
    .rst    (rst),
    .req    (div_req),
    .status (div_st)
  );

  dsl_slew u_slew (
    .target    (scaled),
    .current   (cur_lvl),
    .rise_step (rise_step),
    .level     (slew_out)
  );

  // Sequencer next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd_xfer) begin
          if (cmd.mode == MODE_STOP ||
              (cmd.mode == MODE_SWING && cmd.left_target != '0 &&
               cmd.right_target != '0)) begin
            state_next = S_WRITE;
          end else begin
            state_next = S_PREP;
          end
        end
      end
      S_PREP:  state_next = need_scale ? S_START : S_SLEW;
      S_START: state_next = S_DIV;
      S_DIV: begin
        if (div_st.done) begin
          state_next = S_SLEW;
        end
      end
      S_SLEW:  state_next = (!side && also_right) ? S_PREP : S_WRITE;
      S_WRITE: begin
        if (res_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers: state, configuration, kept levels, result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rise_step  <= RISE_STEP_RESET;
      last_left  <= '0;
      last_right <= '0;
      res_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we && cfg_addr == CFG_RISE_STEP) begin
        rise_step <= cfg_data[STEP_W-1:0];
      end
      if (state == S_WRITE && res_free) begin
        res_valid <= 1'b1;
        if (!stop_cmd) begin
          last_left  <= lo_w;
          last_right <= ro_w;
        end
      end else if (res_xfer) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Command decode and per-side working datapath.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (cmd_xfer) begin
          lt_r     <= cmd.left_target;
          rt_r     <= cmd.right_target;
          lim_r    <= cmd.max_level;
          peak_r   <= (lt_mag > rt_mag) ? lt_mag : rt_mag;
          stop_cmd <= (cmd.mode == MODE_STOP);
          unique case (cmd.mode)
            MODE_STOP: begin
              la_w       <= ACT_BRAKE;
              ra_w       <= ACT_BRAKE;
              lo_w       <= '0;
              ro_w       <= '0;
              done_w     <= 1'b1;
              side       <= 1'b0;
              also_right <= 1'b0;
            end
            MODE_VOLTS, MODE_CHAINED: begin
              la_w       <= ACT_DRIVE;
              ra_w       <= ACT_DRIVE;
              lo_w       <= '0;
              ro_w       <= '0;
              done_w     <= (cmd.mode == MODE_CHAINED);
              side       <= 1'b0;
              also_right <= 1'b1;
            end
            MODE_SWING: begin
              done_w     <= 1'b0;
              also_right <= 1'b0;
              priority if (cmd.right_target == '0) begin
                la_w <= ACT_DRIVE;
                ra_w <= ACT_HOLD;
                lo_w <= '0;
                ro_w <= '0;
                side <= 1'b0;
              end else if (cmd.left_target == '0) begin
                la_w <= ACT_HOLD;
                ra_w <= ACT_DRIVE;
                lo_w <= '0;
                ro_w <= '0;
                side <= 1'b1;
              end else begin
                la_w <= ACT_KEEP;
                ra_w <= ACT_KEEP;
                lo_w <= last_left;
                ro_w <= last_right;
                side <= 1'b0;
              end
            end
            default: begin
              la_w       <= ACT_KEEP;
              ra_w       <= ACT_KEEP;
              lo_w       <= '0;
              ro_w       <= '0;
              done_w     <= 1'b0;
              side       <= 1'b0;
              also_right <= 1'b0;
            end
          endcase
        end
      end
      S_PREP: begin
        prod   <= PROD_W'(mag(side_target)) * PROD_W'(lim_r);
        neg_r  <= side_target[LEVEL_W-1];
        scaled <= side_target;
      end
      S_START: begin
      end
      S_DIV: begin
        if (div_st.done) begin
          scaled <= neg_r ? -quot_s : quot_s;
        end
      end
      S_SLEW: begin
        if (side) begin
          ro_w <= slew_out;
        end else begin
          lo_w <= slew_out;
        end
        if (!side && also_right) begin
          side <= 1'b1;
        end
      end
      S_WRITE: begin
      end
      default: begin
      end
    endcase
  end

  // Result register, loaded as the sequencer finishes.
  always_ff @(posedge clk) begin
    if (state == S_WRITE && res_free) begin
      res_left  <= lo_w;
      res_right <= ro_w;
      res_la    <= la_w;
      res_ra    <= ra_w;
      res_done  <= done_w;
    end
  end

  assign res.valid        = res_valid;
  assign res.left_level   = res_left;
  assign res.right_level  = res_right;
  assign res.left_action  = res_la;
  assign res.right_action = res_ra;
  assign res.done_res     = res_done;

  // The divider only reports a quotient while the sequencer waits for it.
  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_st.done |-> state == S_DIV)
    else $error("quotient arrived outside the divide wait");

  // Kept levels change only when a result is written.
  a_last_stable: assert property (@(posedge clk) disable iff (rst)
    (state != S_WRITE) |=> ($stable(last_left) && $stable(last_right)))
    else $error("kept level changed outside result write");

  // The slewed level lies between the current level and the target.
  a_slew_between: assert property (@(posedge clk) disable iff (rst)
    (state == S_SLEW) |->
      ((slew_out >= scaled && slew_out <= cur_lvl) ||
       (slew_out <= scaled && slew_out >= cur_lvl)))
    else $error("slew output outside current-target window");

endmodule
